// File: sv/sgb_pkg.sv
// Shared types, constants and helpers for the separable Gaussian blur block.
package sgb_pkg;

  localparam int RADIUS_DEF     = 3;
  localparam int MAX_WIDTH_DEF  = 2048;
  localparam int MAX_HEIGHT_DEF = 2048;

  localparam int SAMPLE_W  = 24;
  localparam int TAP_W     = 16;
  localparam int DIM_W     = 12;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;
  localparam int DIST_W    = 2;
  localparam int PROD_W    = SAMPLE_W + TAP_W + 1;
  localparam int ACC_W     = PROD_W + 3;
  localparam int WSUM_W    = TAP_W + 3;
  localparam int QUOT_W    = SAMPLE_W;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_CTR   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_ONE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_TWO   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WEIGHT_THREE = 3'd5;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam logic [DIM_W-1:0] RST_FRAME_WIDTH  = 12'd2048;
  localparam logic [DIM_W-1:0] RST_FRAME_HEIGHT = 12'd2048;
  localparam logic [TAP_W-1:0] RST_WEIGHT_CTR   = 16'd26152;
  localparam logic [TAP_W-1:0] RST_WEIGHT_ONE   = 16'd15862;
  localparam logic [TAP_W-1:0] RST_WEIGHT_TWO   = 16'd3539;
  localparam logic [TAP_W-1:0] RST_WEIGHT_THREE = 16'd290;

  localparam logic signed [SAMPLE_W-1:0] SAT_MAX = 24'sh7FFFFF;
  localparam logic signed [SAMPLE_W-1:0] SAT_MIN = 24'sh800000;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [PROD_W-1:0]   product_t;

  typedef struct packed {
    logic             active;
    logic [TAP_W-1:0] weight;
  } tap_t;

  typedef struct packed {
    logic shift;
    logic ext_sel;
  } cell_cmd_t;

  typedef struct packed {
    logic [TAP_W-1:0] center;
    logic [TAP_W-1:0] one;
    logic [TAP_W-1:0] two;
    logic [TAP_W-1:0] three;
  } weights_t;

  function automatic logic [TAP_W-1:0] tap_weight(input logic [DIST_W-1:0] distance,
                                                  input weights_t w);
    logic [TAP_W-1:0] r;
    unique case (distance)
      2'd0:    r = w.center;
      2'd1:    r = w.one;
      2'd2:    r = w.two;
      default: r = w.three;
    endcase
    return r;
  endfunction

endpackage

// File: sv/sgb_sample_if.sv
// Input channel: pixel or drain transactions.
interface sgb_sample_if;
  import sgb_pkg::*;
  logic    valid;
  logic    ready;
  logic    operation;
  sample_t sample;
  modport source(output valid, operation, sample, input ready);
  modport sink(input valid, operation, sample, output ready);
endinterface

// File: sv/sgb_result_if.sv
// Output channel: filtered pixel transactions.
interface sgb_result_if;
  import sgb_pkg::*;
  logic    valid;
  logic    ready;
  sample_t smoothed;
  logic    frame_end;
  modport source(output valid, smoothed, frame_end, input ready);
  modport sink(input valid, smoothed, frame_end, output ready);
endinterface

// File: sv/sgb_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sgb_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: sv/sgb_cell.sv
// One window cell: holds a sample, passes it on, and forms one weighted product.
module sgb_cell (
  input  logic               clk,
  input  logic               rst,
  input  sgb_pkg::cell_cmd_t cmd,
  input  sgb_pkg::tap_t      tap,
  input  sgb_pkg::sample_t   shift_in,
  input  sgb_pkg::sample_t   ext,
  output sgb_pkg::sample_t   sample,
  output sgb_pkg::product_t  product
);
  import sgb_pkg::*;

  sample_t  operand;
  product_t mult;

  assign operand = cmd.ext_sel ? ext : sample;
  assign mult    = operand * $signed({1'b0, tap.weight});

  always_ff @(posedge clk) begin
    if (rst) begin
      sample <= '0;
    end else if (cmd.shift) begin
      sample <= shift_in;
    end
  end

  // Gate the product so unwritten line entries never reach the sum
  always_ff @(posedge clk) begin
    product <= tap.active ? mult : '0;
  end
endmodule

// File: sv/sgb_divider.sv
// Bit-serial rounding divider: acc / wsum, ties away from zero, saturated to 24 bits.
module sgb_divider (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [sgb_pkg::ACC_W-1:0]    acc,
  input  logic        [sgb_pkg::WSUM_W-1:0]   wsum,
  output logic                                done,
  output sgb_pkg::sample_t                    result
);
  import sgb_pkg::*;

  localparam logic [2:0] D_IDLE  = 3'd0;
  localparam logic [2:0] D_PREP  = 3'd1;
  localparam logic [2:0] D_CHECK = 3'd2;
  localparam logic [2:0] D_ITER  = 3'd3;
  localparam logic [2:0] D_FIN   = 3'd4;
  localparam int CNT_W = $clog2(QUOT_W);
  localparam int NUM_W = ACC_W + 1;
  localparam int DEN_W = WSUM_W + 1;

  logic [2:0]              state;
  logic signed [ACC_W-1:0] acc_r;
  logic [WSUM_W-1:0]       wsum_r;
  logic                    neg_r;
  logic                    zero_r;
  logic                    ovf_r;
  logic [NUM_W-1:0]        num_r;
  logic [DEN_W-1:0]        den_r;
  logic [DEN_W-1:0]        rem;
  logic [QUOT_W-1:0]       low;
  logic [CNT_W-1:0]        count;
  logic [ACC_W-1:0]        mag;
  logic [DEN_W:0]          trial;
  logic                    fits;

  assign mag   = acc_r[ACC_W-1] ? ACC_W'(-acc_r) : ACC_W'(acc_r);
  assign trial = {rem, low[QUOT_W-1]};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        D_IDLE:  if (start) state <= D_PREP;
        D_PREP:  state <= D_CHECK;
        D_CHECK: state <= D_ITER;
        D_ITER:  if (count == CNT_W'(QUOT_W - 1)) state <= D_FIN;
        D_FIN: begin
          done  <= 1'b1;
          state <= D_IDLE;
        end
        default: state <= D_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      D_IDLE: begin
        if (start) begin
          acc_r  <= acc;
          wsum_r <= wsum;
        end
      end
      D_PREP: begin
        neg_r  <= acc_r[ACC_W-1];
        zero_r <= (wsum_r == '0);
        num_r  <= {mag, 1'b0} + NUM_W'(wsum_r);
        den_r  <= {wsum_r, 1'b0};
      end
      D_CHECK: begin
        // A quotient of 2^24 or more saturates either way
        ovf_r <= num_r >= {1'b0, den_r, {QUOT_W{1'b0}}};
        rem   <= num_r[NUM_W-2 -: DEN_W];
        low   <= num_r[QUOT_W-1:0];
        count <= '0;
      end
      D_ITER: begin
        rem   <= fits ? DEN_W'(trial - {1'b0, den_r}) : trial[DEN_W-1:0];
        low   <= {low[QUOT_W-2:0], fits};
        count <= count + CNT_W'(1);
      end
      D_FIN: begin
        if (zero_r) begin
          result <= '0;
        end else if (neg_r) begin
          result <= (ovf_r || low > 24'd8388608) ? SAT_MIN : SAMPLE_W'(-{1'b0, low});
        end else begin
          result <= (ovf_r || low > 24'd8388607) ? SAT_MAX : sample_t'(low);
        end
      end
      default: ;
    endcase
  end
endmodule

// File: sv/separable_gaussian_blur_renorm_top.sv
// Top level: separable Gaussian blur with edge renormalisation over a chain of window cells.
// Every pass waits on the 24-step divider. A pixel transaction runs a horizontal pass
// once its column reaches RADIUS or ends a row, and a vertical pass if it yields an output;
// the last pixel of a row adds up to RADIUS more horizontal passes. A drain transaction runs a vertical pass.
// Items are processed one at a time; a result waits in the output register meanwhile.
// Synchronous reset clears counters, window cells and output valid; the line store is not cleared.
module separable_gaussian_blur_renorm_top #(
  parameter int RADIUS     = sgb_pkg::RADIUS_DEF,
  parameter int MAX_WIDTH  = sgb_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = sgb_pkg::MAX_HEIGHT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [sgb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sgb_pkg::CFG_W-1:0]      cfg_data,
  sgb_sample_if.sink                     samples,
  sgb_result_if.source                   results
);
  import sgb_pkg::*;

  localparam int WIN    = 2 * RADIUS + 1;
  // narrow frames keep up to 3*RADIUS+1 rows live between write and last read
  localparam int NSLOT  = 3 * RADIUS + 1;
  localparam int SLOT_W = $clog2(NSLOT);
  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = $clog2(MAX_HEIGHT);
  localparam int WID_W  = COL_W + 1;
  localparam int HGT_W  = ROW_W + 1;
  localparam int P_W    = ROW_W + WID_W + 1;
  localparam int Y_W    = ROW_W + 2;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_HMUL  = 4'd1;
  localparam logic [3:0] S_HSUM  = 4'd2;
  localparam logic [3:0] S_HDIV  = 4'd3;
  localparam logic [3:0] S_CHECK = 4'd4;
  localparam logic [3:0] S_VRD   = 4'd5;
  localparam logic [3:0] S_VMUL  = 4'd6;
  localparam logic [3:0] S_VSUM  = 4'd7;
  localparam logic [3:0] S_VDIV  = 4'd8;
  localparam logic [3:0] S_VOUT  = 4'd9;

  // configuration
  logic [DIM_W-1:0] frame_width;
  logic [DIM_W-1:0] frame_height;
  weights_t         weights;
  logic [WID_W-1:0] width_eff;
  logic [HGT_W-1:0] height_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width   <= RST_FRAME_WIDTH;
      frame_height  <= RST_FRAME_HEIGHT;
      weights.center <= RST_WEIGHT_CTR;
      weights.one    <= RST_WEIGHT_ONE;
      weights.two    <= RST_WEIGHT_TWO;
      weights.three  <= RST_WEIGHT_THREE;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  frame_width   <= cfg_data[DIM_W-1:0];
        REG_FRAME_HEIGHT: frame_height  <= cfg_data[DIM_W-1:0];
        REG_WEIGHT_CTR:   weights.center <= cfg_data[TAP_W-1:0];
        REG_WEIGHT_ONE:   weights.one    <= cfg_data[TAP_W-1:0];
        REG_WEIGHT_TWO:   weights.two    <= cfg_data[TAP_W-1:0];
        REG_WEIGHT_THREE: weights.three  <= cfg_data[TAP_W-1:0];
        default: ;
      endcase
    end
  end

  assign width_eff  = (frame_width == '0) ? WID_W'(1) :
                      ({1'b0, frame_width} > (DIM_W+1)'(MAX_WIDTH)) ? WID_W'(MAX_WIDTH) :
                      WID_W'(frame_width);
  assign height_eff = (frame_height == '0) ? HGT_W'(1) :
                      ({1'b0, frame_height} > (DIM_W+1)'(MAX_HEIGHT)) ? HGT_W'(MAX_HEIGHT) :
                      HGT_W'(frame_height);

  // control state
  logic [3:0]        state;
  logic [COL_W-1:0]  in_column;
  logic [ROW_W-1:0]  in_row;
  logic [SLOT_W-1:0] in_slot;
  logic [COL_W-1:0]  out_column;
  logic [ROW_W-1:0]  out_row;
  logic [SLOT_W-1:0] out_slot;
  logic              complete;
  logic [DIST_W-1:0] d_q;
  logic [DIST_W-1:0] d_end_q;

  // per-item payload
  logic [COL_W-1:0]  ix_q;
  logic [ROW_W-1:0]  iy_q;
  logic [SLOT_W-1:0] wslot_q;

  logic              accept;
  logic              pixel_take;
  logic              drain_take;
  logic              row_end;
  logic              col_past_radius;
  logic [DIST_W-1:0] d_start;
  logic              emit_go;
  logic [P_W-1:0]    pix_index;
  logic [P_W-1:0]    lag;
  logic              out_free;
  logic              out_load;
  logic              frame_last;
  logic              out_col_end;

  assign samples.ready   = (state == S_IDLE);
  assign accept          = samples.valid && samples.ready;
  assign pixel_take      = accept && (samples.operation == OP_PIXEL) && !complete;
  assign drain_take      = accept && (samples.operation == OP_DRAIN) && complete;
  assign row_end         = (WID_W'(in_column) + WID_W'(1)) >= width_eff;
  assign col_past_radius = in_column >= COL_W'(RADIUS);
  assign d_start         = col_past_radius ? DIST_W'(RADIUS) : in_column[DIST_W-1:0];

  assign pix_index = P_W'(iy_q) * P_W'(width_eff) + P_W'(ix_q);
  assign lag       = P_W'(RADIUS) * P_W'(width_eff) + P_W'(RADIUS);
  assign emit_go   = pix_index >= lag;

  assign out_col_end = (WID_W'(out_column) + WID_W'(1)) >= width_eff;
  assign frame_last  = out_col_end && ((HGT_W'(out_row) + HGT_W'(1)) >= height_eff);

  logic out_valid;
  assign out_free = !out_valid || results.ready;
  assign out_load = (state == S_VOUT) && out_free;

  // divider
  logic                     div_start;
  logic                     div_done;
  sample_t                  div_result;
  logic signed [ACC_W-1:0]  acc_sum;
  logic [WSUM_W-1:0]        wsum_next;
  logic [WSUM_W-1:0]        wsum_q;

  assign div_start = (state == S_HSUM) || (state == S_VSUM);

  sgb_divider u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .acc    (acc_sum),
    .wsum   (wsum_q),
    .done   (div_done),
    .result (div_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      in_column  <= '0;
      in_row     <= '0;
      in_slot    <= '0;
      out_column <= '0;
      out_row    <= '0;
      out_slot   <= '0;
      complete   <= 1'b0;
      d_q        <= '0;
      d_end_q    <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (pixel_take) begin
            d_q     <= d_start;
            d_end_q <= row_end ? '0 : d_start;
            if (row_end) begin
              in_column <= '0;
              if ((HGT_W'(in_row) + HGT_W'(1)) >= height_eff) begin
                in_row   <= '0;
                in_slot  <= '0;
                complete <= 1'b1;
              end else begin
                in_row  <= in_row + ROW_W'(1);
                in_slot <= (in_slot == SLOT_W'(NSLOT - 1)) ? '0 : in_slot + SLOT_W'(1);
              end
            end else begin
              in_column <= in_column + COL_W'(1);
            end
            state <= (col_past_radius || row_end) ? S_HMUL : S_CHECK;
          end else if (drain_take) begin
            state <= S_VRD;
          end
        end
        S_HMUL: state <= S_HSUM;
        S_HSUM: state <= S_HDIV;
        S_HDIV: begin
          if (div_done) begin
            if (d_q == d_end_q) begin
              state <= S_CHECK;
            end else begin
              d_q   <= d_q - DIST_W'(1);
              state <= S_HMUL;
            end
          end
        end
        S_CHECK: state <= emit_go ? S_VRD : S_IDLE;
        S_VRD:   state <= S_VMUL;
        S_VMUL:  state <= S_VSUM;
        S_VSUM:  state <= S_VDIV;
        S_VDIV:  if (div_done) state <= S_VOUT;
        S_VOUT: begin
          if (out_free) begin
            if (frame_last) begin
              in_column  <= '0;
              in_row     <= '0;
              in_slot    <= '0;
              out_column <= '0;
              out_row    <= '0;
              out_slot   <= '0;
              complete   <= 1'b0;
            end else if (out_col_end) begin
              out_column <= '0;
              out_row    <= out_row + ROW_W'(1);
              out_slot   <= (out_slot == SLOT_W'(NSLOT - 1)) ? '0 : out_slot + SLOT_W'(1);
            end else begin
              out_column <= out_column + COL_W'(1);
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pixel_take) begin
      ix_q    <= in_column;
      iy_q    <= in_row;
      wslot_q <= in_slot;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      results.smoothed  <= div_result;
      results.frame_end <= frame_last;
    end
  end

  assign results.valid = out_valid;

  // tap selection per cell: horizontal uses distance from the target column,
  // vertical gives cell j the row offset j - RADIUS from the output row
  tap_t      taps [WIN];
  cell_cmd_t cmd;
  sample_t   chain [WIN];
  sample_t   cell_ext [WIN];
  sample_t   bank_data [NSLOT];
  product_t  prods [WIN];
  logic [NSLOT-1:0] bank_we;
  logic [COL_W-1:0] wcol;

  logic signed [3:0] hdist;
  logic [3:0]        habs;
  logic signed [3:0] voff;
  logic [3:0]        vabs;
  logic signed [Y_W-1:0] vrow;
  logic [SLOT_W:0]   bsum;
  logic [SLOT_W:0]   bidx;

  always_comb begin
    hdist = '0;
    habs  = '0;
    voff  = '0;
    vabs  = '0;
    vrow  = '0;
    for (int j = 0; j < WIN; j++) begin
      taps[j] = '0;
      if (state == S_HMUL) begin
        hdist = $signed({2'b00, d_q}) - 4'(j);
        habs  = hdist[3] ? 4'(-hdist) : 4'(hdist);
        taps[j].active = (ix_q >= COL_W'(j)) && (habs <= 4'(RADIUS)) &&
                         ((WID_W'(ix_q) - WID_W'(j)) < width_eff);
        taps[j].weight = tap_weight(habs[DIST_W-1:0], weights);
      end else begin
        voff = $signed(4'(j) - 4'(RADIUS));
        vabs = voff[3] ? 4'(-voff) : 4'(voff);
        vrow = $signed({2'b00, out_row}) + Y_W'(voff);
        taps[j].active = !vrow[Y_W-1] && (vrow < $signed({1'b0, height_eff}));
        taps[j].weight = tap_weight(vabs[DIST_W-1:0], weights);
      end
    end
  end

  // route the bank that holds row out_row + j - RADIUS to cell j
  always_comb begin
    bsum = '0;
    bidx = '0;
    for (int j = 0; j < WIN; j++) begin
      bsum = (SLOT_W+1)'(out_slot) + (SLOT_W+1)'(j);
      if (bsum >= (SLOT_W+1)'(RADIUS)) begin
        bidx = bsum - (SLOT_W+1)'(RADIUS);
      end else begin
        bidx = bsum + (SLOT_W+1)'(NSLOT - RADIUS);
      end
      if (bidx >= (SLOT_W+1)'(NSLOT)) begin
        bidx = bidx - (SLOT_W+1)'(NSLOT);
      end
      cell_ext[j] = bank_data[bidx[SLOT_W-1:0]];
    end
  end

  always_comb begin
    wsum_next = '0;
    acc_sum   = '0;
    for (int j = 0; j < WIN; j++) begin
      if (taps[j].active) begin
        wsum_next = wsum_next + WSUM_W'(taps[j].weight);
      end
      acc_sum = acc_sum + ACC_W'(prods[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_HMUL || state == S_VMUL) begin
      wsum_q <= wsum_next;
    end
  end

  assign cmd.shift   = pixel_take;
  assign cmd.ext_sel = (state == S_VMUL);
  assign wcol        = ix_q - COL_W'(d_q);

  genvar g;
  generate
    for (g = 0; g < WIN; g++) begin : g_cell
      sgb_cell u_cell (
        .clk      (clk),
        .rst      (rst),
        .cmd      (cmd),
        .tap      (taps[g]),
        .shift_in ((g == 0) ? samples.sample : chain[(g == 0) ? 0 : g - 1]),
        .ext      (cell_ext[g]),
        .sample   (chain[g]),
        .product  (prods[g])
      );
    end

    for (g = 0; g < NSLOT; g++) begin : g_bank
      assign bank_we[g] = (state == S_HDIV) && div_done && (wslot_q == SLOT_W'(g));

      // one line-store bank per row slot
      sgb_ram #(
        .WIDTH (SAMPLE_W),
        .DEPTH (MAX_WIDTH)
      ) u_bank (
        .clk   (clk),
        .we    (bank_we[g]),
        .waddr (wcol),
        .wdata (div_result),
        .raddr (out_column),
        .rdata (bank_data[g])
      );
    end
  endgenerate

`ifndef ASSERT_OFF
  a_one_bank_write: assert property (@(posedge clk) disable iff (rst)
    $onehot0(bank_we))
    else $error("more than one line-store bank written");

  a_div_done_owned: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == S_HDIV || state == S_VDIV))
    else $error("divider finished outside a divide state");

  a_complete_clear: assert property (@(posedge clk) disable iff (rst)
    $fell(complete) |-> ($past(out_load && frame_last) || $past(rst)))
    else $error("input-complete cleared without a frame end transaction");

  a_out_from_vout: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_VOUT))
    else $error("result raised outside the output state");
`endif
endmodule
